@@ hw/rtl/amam_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// amam_pkg
// Shared widths, register codes, reset values and types for the converter
// moving-average monitor.
// ----------------------------------------------------------------------------
package amam_pkg;

    localparam int SAMPLE_W       = 12;
    localparam int MV_W           = 12;
    localparam int GAIN_W         = 10;
    localparam int MEAS_W         = 23;
    localparam int CFG_ADDR_W     = 2;
    localparam int CFG_DATA_W     = 12;
    localparam int WINDOW_DEFAULT = 200;

    localparam logic [SAMPLE_W-1:0] THRESHOLD_RST = 12'd1638;
    localparam logic [MV_W-1:0]     REFERENCE_RST = 12'd2500;
    localparam logic [GAIN_W-1:0]   GAIN_RST      = 10'd772;
    localparam logic [MV_W-1:0]     OFFSET_RST    = 12'd1286;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_ALARM_THRESHOLD = 2'd0,
        CFG_REFERENCE_MV    = 2'd1,
        CFG_SCALE_GAIN      = 2'd2,
        CFG_OFFSET_MV       = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] alarm_threshold;
        logic [MV_W-1:0]     reference_mv;
        logic [GAIN_W-1:0]   scale_gain;
        logic [MV_W-1:0]     offset_mv;
    } cfg_t;

    typedef struct packed {
        logic                     over_threshold;
        logic signed [MEAS_W-1:0] measured_mv;
        logic [MV_W-1:0]          sensed_mv;
        logic [SAMPLE_W-1:0]      mean_sample;
    } result_t;

endpackage
`default_nettype wire

@@ hw/rtl/amam_math.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// amam_math
// Six-stage result pipeline: divides the window sum by the window length
// through a reciprocal multiply with one correction step, converts the mean
// to millivolts, applies offset and gain, and compares against the alarm
// threshold. Each stage holds its item until the next stage can take it.
// ----------------------------------------------------------------------------
module amam_math
    import amam_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEFAULT,
    localparam int SUM_W = $clog2(WINDOW * (2 ** SAMPLE_W - 1) + 1)
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [SUM_W-1:0] in_sum,
    input  wire cfg_t             cfg,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output result_t               out_result
);

    localparam int REM_W = $clog2(2 * WINDOW);
    localparam logic [SUM_W-1:0] RECIP = SUM_W'((2 ** SUM_W) / WINDOW);
    localparam logic [SUM_W-1:0] WIN_S = SUM_W'(WINDOW);
    localparam logic [REM_W-1:0] WIN_R = REM_W'(WINDOW);

    logic [6:1] valid_reg;
    logic [6:1] rdy;

    logic [2*SUM_W-1:0]       prod_reg;
    logic [SUM_W-1:0]         sum1_reg;
    logic [SAMPLE_W-1:0]      qest_reg;
    logic [REM_W-1:0]         rem_reg;
    logic [SAMPLE_W-1:0]      mean3_reg;
    logic                     over3_reg;
    logic [2*MV_W-1:0]        mv_prod_reg;
    logic [SAMPLE_W-1:0]      mean4_reg;
    logic                     over4_reg;
    logic signed [MV_W:0]     diff_reg;
    logic [MV_W-1:0]          sensed5_reg;
    logic [SAMPLE_W-1:0]      mean5_reg;
    logic                     over5_reg;
    result_t                  result_reg;

    logic [SAMPLE_W-1:0]      qest_next;
    logic [SUM_W-1:0]         qd;
    logic [SUM_W-1:0]         rem_full;
    logic [SAMPLE_W-1:0]      mean_next;
    logic [MV_W-1:0]          sensed_next;
    logic signed [MV_W:0]     diff_next;
    logic signed [MEAS_W:0]   meas_full;

    assign rdy[6] = !valid_reg[6] || out_ready;
    assign rdy[5] = !valid_reg[5] || rdy[6];
    assign rdy[4] = !valid_reg[4] || rdy[5];
    assign rdy[3] = !valid_reg[3] || rdy[4];
    assign rdy[2] = !valid_reg[2] || rdy[3];
    assign rdy[1] = !valid_reg[1] || rdy[2];

    assign in_ready   = rdy[1];
    assign out_valid  = valid_reg[6];
    assign out_result = result_reg;

    assign qest_next   = prod_reg[SUM_W +: SAMPLE_W];
    assign qd          = SUM_W'(qest_next * WIN_S);
    assign rem_full    = sum1_reg - qd;
    assign mean_next   = qest_reg + SAMPLE_W'(rem_reg >= WIN_R);
    assign sensed_next = mv_prod_reg[2*MV_W-1:MV_W];
    assign diff_next   = $signed({1'b0, sensed_next}) - $signed({1'b0, cfg.offset_mv});
    assign meas_full   = diff_reg * $signed({1'b0, cfg.scale_gain});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (rdy[1]) valid_reg[1] <= in_valid;
            if (rdy[2]) valid_reg[2] <= valid_reg[1];
            if (rdy[3]) valid_reg[3] <= valid_reg[2];
            if (rdy[4]) valid_reg[4] <= valid_reg[3];
            if (rdy[5]) valid_reg[5] <= valid_reg[4];
            if (rdy[6]) valid_reg[6] <= valid_reg[5];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            prod_reg <= in_sum * RECIP;
            sum1_reg <= in_sum;
        end
        if (rdy[2])
        begin
            qest_reg <= qest_next;
            rem_reg  <= rem_full[REM_W-1:0];
        end
        if (rdy[3])
        begin
            mean3_reg <= mean_next;
            over3_reg <= (mean_next >= cfg.alarm_threshold);
        end
        if (rdy[4])
        begin
            mv_prod_reg <= mean3_reg * cfg.reference_mv;
            mean4_reg   <= mean3_reg;
            over4_reg   <= over3_reg;
        end
        if (rdy[5])
        begin
            diff_reg    <= diff_next;
            sensed5_reg <= sensed_next;
            mean5_reg   <= mean4_reg;
            over5_reg   <= over4_reg;
        end
        if (rdy[6])
        begin
            result_reg.mean_sample    <= mean5_reg;
            result_reg.sensed_mv      <= sensed5_reg;
            result_reg.measured_mv    <= meas_full[MEAS_W-1:0];
            result_reg.over_threshold <= over5_reg;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/adc_moving_average_monitor_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// adc_moving_average_monitor_top
// Boxcar moving average over the last WINDOW converter samples with a
// millivolt readout and an over-threshold flag.
//
// Channel  Direction  Data
// s_axis   in         s_tdata[11:0] sample
// m_axis   out        m_tdata mean_sample, sensed_mv, measured_mv, over_threshold
// cfg      in         cfg_addr register index, cfg_wdata value
//
// An item is taken only in the idle state, so a sample waits until the
// last is through: the cycle that takes it reads the ring entry that is
// about to be overwritten, the next writes the new sample and updates the
// running sum. The ring memory is not cleared after reset; its entries are
// read on every item but enter the sum only once every one has been written.
// A stalled output fills the result pipeline and then holds s_tready low.
// ----------------------------------------------------------------------------
module adc_moving_average_monitor_top
    import amam_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEFAULT
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [15:0]           s_tdata,   // [11:0] sample
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [47:0]                m_tdata,   // mean_sample, sensed_mv,
                                                  // measured_mv, over_threshold
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int SUM_W = $clog2(WINDOW * (2 ** SAMPLE_W - 1) + 1);
    localparam int PTR_W = $clog2(WINDOW);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW - 1);

    typedef enum logic {
        ST_IDLE,
        ST_UPDATE
    } state_t;

    state_t              state_reg;
    logic [PTR_W-1:0]    pos_reg;
    logic [PTR_W-1:0]    pos_next;
    logic                filled_reg;
    logic                filled_next;
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    sum_next;
    logic                st0_valid_reg;
    logic [SUM_W-1:0]    st0_sum_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic [SAMPLE_W-1:0] ring_mem [WINDOW];
    cfg_t                cfg_reg;
    logic                math_ready;
    logic                accept;
    result_t             result;

    assign s_tready = (state_reg == ST_IDLE) && (!st0_valid_reg || math_ready);
    assign accept   = s_tvalid && s_tready;

    assign pos_next    = (pos_reg == PTR_LAST) ? '0 : pos_reg + PTR_W'(1);
    assign filled_next = filled_reg || (pos_reg == PTR_LAST);
    assign sum_next    = sum_reg - (filled_reg ? SUM_W'(rd_data_reg) : '0)
                         + SUM_W'(sample_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            filled_reg    <= 1'b0;
            sum_reg       <= '0;
            st0_valid_reg <= 1'b0;
        end
        else
        begin
            if (st0_valid_reg && math_ready)
            begin
                st0_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_UPDATE;
                    end
                end
                ST_UPDATE:
                begin
                    pos_reg       <= pos_next;
                    filled_reg    <= filled_next;
                    sum_reg       <= sum_next;
                    st0_valid_reg <= filled_next;
                    state_reg     <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg  <= s_tdata[SAMPLE_W-1:0];
            rd_data_reg <= ring_mem[pos_reg];
        end
        if (state_reg == ST_UPDATE)
        begin
            ring_mem[pos_reg] <= sample_reg;
            st0_sum_reg       <= sum_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.alarm_threshold <= THRESHOLD_RST;
            cfg_reg.reference_mv    <= REFERENCE_RST;
            cfg_reg.scale_gain      <= GAIN_RST;
            cfg_reg.offset_mv       <= OFFSET_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index_t'(cfg_addr))
                CFG_ALARM_THRESHOLD: cfg_reg.alarm_threshold <= cfg_wdata[SAMPLE_W-1:0];
                CFG_REFERENCE_MV:    cfg_reg.reference_mv    <= cfg_wdata[MV_W-1:0];
                CFG_SCALE_GAIN:      cfg_reg.scale_gain      <= cfg_wdata[GAIN_W-1:0];
                CFG_OFFSET_MV:       cfg_reg.offset_mv       <= cfg_wdata[MV_W-1:0];
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    amam_math #(
        .WINDOW (WINDOW)
    ) u_math (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (st0_valid_reg),
        .in_ready   (math_ready),
        .in_sum     (st0_sum_reg),
        .cfg        (cfg_reg),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    assign m_tdata = {result.over_threshold, result.measured_mv,
                      result.sensed_mv, result.mean_sample};

endmodule
`default_nettype wire

@@ bench/adc_moving_average_monitor_top_tb.sv @@
// ----------------------------------------------------------------------------
// adc_moving_average_monitor_top_tb
// Self-checking bench for the converter moving-average monitor. A table of
// directed runs covers the fill of the ring, the sample and register
// extremes and a masked register write. Random phases of samples under
// random register settings follow. Every result is checked against a bench
// model of the window, or the table's value for marked rows, with random
// gaps on both streams and one long output stall.
// ----------------------------------------------------------------------------
module adc_moving_average_monitor_top_tb;
    import amam_pkg::*;

    localparam int WIN            = WINDOW_DEFAULT;
    localparam int RANDOM_SAMPLES = 440;
    localparam int SETTLE_CYCLES  = 16;
    localparam int LONG_HOLD      = 400;
    localparam int STALL_LIMIT    = 5000;

    typedef enum {ROW_RUN, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        cfg_index_t  cfg_sel;
        logic [11:0] value;
        int          reps;
        bit          typed;
        result_t     want;
    } dir_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [15:0]           s_tdata;    // [11:0] sample
    logic                  m_tvalid;
    logic                  m_tready;
    logic [47:0]           m_tdata;    // [11:0] mean_sample, [23:12] sensed_mv,
                                       // [46:24] measured_mv, [47] over_threshold
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    result_t               pending_averages[$];
    int                    errors;
    int                    idle_cycles;
    bit                    quiet;
    bit                    stall_request;

    logic [SAMPLE_W-1:0]   ring_copy [WIN];
    int                    wr_pos;
    bit                    ring_full;
    logic [19:0]           ring_sum;
    cfg_t                  regs;

    adc_moving_average_monitor_top #(
        .WINDOW (WIN)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic result_t make_result(input int mean, input int sensed, input int meas,
                                            input bit over);
        result_t r;
        r.mean_sample    = mean[11:0];
        r.sensed_mv      = sensed[11:0];
        r.measured_mv    = meas[22:0];
        r.over_threshold = over;
        return r;
    endfunction

    function automatic int gap_len();
        int pick;
        if (quiet)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        if (pick < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic compute_average(input logic [11:0] s, output bit produced,
                                   output result_t r);
        logic [23:0] scaled;
        int          diff;
        int          meas;
        if (ring_full)
            ring_sum = ring_sum - ring_copy[wr_pos];
        ring_copy[wr_pos] = s;
        ring_sum = ring_sum + s;
        if (wr_pos == WIN - 1)
        begin
            wr_pos    = 0;
            ring_full = 1'b1;
        end
        else
            wr_pos++;
        produced = ring_full;
        r.mean_sample    = 12'(ring_sum / WIN);
        scaled           = r.mean_sample * regs.reference_mv;
        r.sensed_mv      = scaled[23:12];
        diff             = int'(r.sensed_mv) - int'(regs.offset_mv);
        meas             = diff * int'(regs.scale_gain);
        r.measured_mv    = meas[22:0];
        r.over_threshold = (r.mean_sample >= regs.alarm_threshold);
    endtask

    task automatic write_reg(input cfg_index_t sel, input logic [11:0] v);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= sel;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        case (sel)
            CFG_ALARM_THRESHOLD: regs.alarm_threshold = v;
            CFG_REFERENCE_MV:    regs.reference_mv    = v;
            CFG_SCALE_GAIN:      regs.scale_gain      = v[GAIN_W-1:0];
            CFG_OFFSET_MV:       regs.offset_mv       = v;
        endcase
    endtask

    task automatic send_sample(input logic [11:0] v, input bit typed, input result_t want);
        int      gap;
        bit      produced;
        result_t r;
        gap = gap_len();
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, v};
        do
            @(posedge clk);
        while (!s_tready);
        compute_average(v, produced, r);
        if (produced)
            pending_averages.push_back(typed ? want : r);
    endtask

    // Items that complete no window leave the block busy after the last result.
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_averages.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : ready_drive
        int n;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (stall_request)
            begin
                repeat (LONG_HOLD)
                begin
                    @(negedge clk);
                    m_tready <= 1'b0;
                end
                stall_request = 1'b0;
            end
            n = gap_len();
            repeat (n)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
            end
            n = $urandom_range(1, 8);
            repeat (n)
            begin
                @(negedge clk);
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : check_output
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (pending_averages.size() == 0)
            begin
                $display("%0t: unexpected item, actual %h", $time, m_tdata);
                errors++;
            end
            else
            begin
                want = pending_averages.pop_front();
                if (got.mean_sample !== want.mean_sample)
                begin
                    $display("%0t: mean_sample expected %0d actual %0d",
                             $time, want.mean_sample, got.mean_sample);
                    errors++;
                end
                if (got.sensed_mv !== want.sensed_mv)
                begin
                    $display("%0t: sensed_mv expected %0d actual %0d",
                             $time, want.sensed_mv, got.sensed_mv);
                    errors++;
                end
                if (got.measured_mv !== want.measured_mv)
                begin
                    $display("%0t: measured_mv expected %0d actual %0d",
                             $time, want.measured_mv, got.measured_mv);
                    errors++;
                end
                if (got.over_threshold !== want.over_threshold)
                begin
                    $display("%0t: over_threshold expected %0d actual %0d",
                             $time, want.over_threshold, got.over_threshold);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("adc_moving_average_monitor_top: mismatch");
            $finish;
        end
    end

    initial
    begin : stimulus
        dir_row_t    directed_rows[$];
        result_t     none;
        logic [11:0] v;
        int          sent;
        int          batch;
        int          mode;
        int          level;

        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        cfg_wr_en     = 1'b0;
        cfg_addr      = CFG_ALARM_THRESHOLD;
        cfg_wdata     = '0;
        errors        = 0;
        idle_cycles   = 0;
        quiet         = 1'b0;
        stall_request = 1'b0;
        wr_pos        = 0;
        ring_full     = 1'b0;
        ring_sum      = '0;
        regs          = '{THRESHOLD_RST, REFERENCE_RST, GAIN_RST, OFFSET_RST};
        none          = '0;

        // Fill the ring up to one short of a wrap, then complete it.
        directed_rows.push_back('{ROW_RUN, CFG_ALARM_THRESHOLD, 12'd0, 199, 1'b0, none});
        directed_rows.push_back('{ROW_RUN, CFG_ALARM_THRESHOLD, 12'd4095, 1, 1'b0, none});
        directed_rows.push_back('{ROW_RUN, CFG_ALARM_THRESHOLD, 12'd4095, 199, 1'b1,
                                  make_result(4095, 2499, 936436, 1'b1)});
        directed_rows.push_back('{ROW_RUN, CFG_ALARM_THRESHOLD, 12'd0, 200, 1'b1,
                                  make_result(0, 0, -992792, 1'b0)});
        directed_rows.push_back('{ROW_REG, CFG_ALARM_THRESHOLD, 12'd4095, 0, 1'b0, none});
        directed_rows.push_back('{ROW_REG, CFG_REFERENCE_MV, 12'd4095, 0, 1'b0, none});
        directed_rows.push_back('{ROW_REG, CFG_SCALE_GAIN, 12'd1023, 0, 1'b0, none});
        directed_rows.push_back('{ROW_REG, CFG_OFFSET_MV, 12'd0, 0, 1'b0, none});
        directed_rows.push_back('{ROW_RUN, CFG_ALARM_THRESHOLD, 12'd4095, 200, 1'b1,
                                  make_result(4095, 4094, 4188162, 1'b1)});
        directed_rows.push_back('{ROW_RUN, CFG_ALARM_THRESHOLD, 12'd4094, 200, 1'b0, none});
        directed_rows.push_back('{ROW_REG, CFG_OFFSET_MV, 12'd4095, 0, 1'b0, none});
        directed_rows.push_back('{ROW_RUN, CFG_ALARM_THRESHOLD, 12'd0, 200, 1'b1,
                                  make_result(0, 0, -4189185, 1'b0)});
        directed_rows.push_back('{ROW_REG, CFG_ALARM_THRESHOLD, 12'd0, 0, 1'b0, none});
        directed_rows.push_back('{ROW_RUN, CFG_ALARM_THRESHOLD, 12'hAAA, 50, 1'b0, none});
        directed_rows.push_back('{ROW_RUN, CFG_ALARM_THRESHOLD, 12'h555, 50, 1'b0, none});
        directed_rows.push_back('{ROW_REG, CFG_SCALE_GAIN, 12'hFFF, 0, 1'b0, none});
        directed_rows.push_back('{ROW_RUN, CFG_ALARM_THRESHOLD, 12'h800, 3, 1'b0, none});
        directed_rows.push_back('{ROW_REG, CFG_ALARM_THRESHOLD, THRESHOLD_RST, 0, 1'b0, none});
        directed_rows.push_back('{ROW_REG, CFG_REFERENCE_MV, REFERENCE_RST, 0, 1'b0, none});
        directed_rows.push_back('{ROW_REG, CFG_SCALE_GAIN, 12'(GAIN_RST), 0, 1'b0, none});
        directed_rows.push_back('{ROW_REG, CFG_OFFSET_MV, OFFSET_RST, 0, 1'b0, none});

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_REG)
            begin
                settle();
                write_reg(directed_rows[i].cfg_sel, directed_rows[i].value);
            end
            else
            begin
                for (int k = 0; k < directed_rows[i].reps; k++)
                    send_sample(directed_rows[i].value,
                                directed_rows[i].typed && (k == directed_rows[i].reps - 1),
                                directed_rows[i].want);
            end
        end

        sent = 0;
        while (sent < RANDOM_SAMPLES)
        begin
            settle();
            for (int i = 0; i < 4; i++)
            begin
                if ($urandom_range(0, 1) == 1)
                begin
                    case ($urandom_range(0, 3))
                        0:       v = 12'd0;
                        1:       v = 12'hFFF;
                        default: v = 12'($urandom_range(0, 4095));
                    endcase
                    write_reg(cfg_index_t'(i), v);
                end
            end
            if (sent == 0)
                stall_request = 1'b1;
            quiet = ($urandom_range(0, 3) == 0);
            mode  = $urandom_range(0, 3);
            batch = $urandom_range(40, 160);
            level = $urandom_range(0, 4095);
            repeat (batch)
            begin
                case (mode)
                    0: v = 12'($urandom_range(0, 4095));
                    1:
                    begin
                        case ($urandom_range(0, 2))
                            0:       v = 12'd0;
                            1:       v = 12'hFFF;
                            default: v = 12'($urandom);
                        endcase
                    end
                    2:
                    begin
                        level = level + $urandom_range(0, 64) - 32;
                        if (level < 0)
                            level = 0;
                        if (level > 4095)
                            level = 4095;
                        v = level[11:0];
                    end
                    default:
                        v = ($urandom_range(0, 19) == 0) ? 12'($urandom_range(0, 4095))
                                                         : level[11:0];
                endcase
                send_sample(v, 1'b0, none);
                sent++;
            end
        end
        quiet = 1'b0;

        settle();
        if (errors == 0)
            $display("adc_moving_average_monitor_top: match");
        else
            $display("adc_moving_average_monitor_top: mismatch");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/amam_pkg.sv
hw/rtl/amam_math.sv
hw/rtl/adc_moving_average_monitor_top.sv
bench/adc_moving_average_monitor_top_tb.sv
